// ===== hdl/patf_pkg.sv =====
// Shared types and constants for the phase-angle thyristor firing core.
// No dependencies; every other file imports this package.
`default_nettype none

package patf_pkg;

  localparam int CHANNELS = 2;
  localparam int CHAN_PAD = 8;

  localparam logic [6:0] PCT_FULL   = 7'd100;
  localparam logic [8:0] OFF_MARGIN = 9'd10;

  localparam logic [6:0] DUTY_MAX_RST = 7'd95;
  localparam logic [6:0] DUTY_MIN_RST = 7'd5;
  localparam logic [7:0] PERIOD_RST   = 8'd100;

  // item modes (code 3 is unused and ignored)
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ZERO = 2'd1;
  localparam logic [1:0] MODE_DUTY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DUTY_MAX = 2'd0;
  localparam logic [1:0] REG_DUTY_MIN = 2'd1;
  localparam logic [1:0] REG_PERIOD   = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic       channel;
    logic [7:0] duty_value;
  } in_t;

  typedef struct packed {
    logic gate_ch0;
    logic gate_ch1;
    logic timing_active;
  } out_t;

  typedef struct packed {
    logic [6:0] duty_max;
    logic [6:0] duty_min;
    logic [7:0] period_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/patf_engine.sv =====
// Firing state and per-item update: duty store, compare points, tick timer, gates.
// Depends on patf_pkg.
`default_nettype none

module patf_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire patf_pkg::in_t  item,
  input  wire patf_pkg::cfg_t cfg,
  output patf_pkg::out_t      result
);
  import patf_pkg::*;

  logic [6:0]          duty_store      [CHANNELS];
  logic [6:0]          duty_store_next [CHANNELS];
  logic [8:0]          compare_point      [CHANNELS];
  logic [8:0]          compare_point_next [CHANNELS];
  logic [7:0]          tick_count, tick_count_next;
  logic                timer_running, timer_running_next;
  logic [CHANNELS-1:0] gate_level, gate_level_next;
  logic [7:0]          duty_clamped;
  logic [CHAN_PAD-1:0] gate_pad;

  always_comb begin
    if (item.duty_value > {1'b0, cfg.duty_max}) begin
      duty_clamped = {1'b0, cfg.duty_max};
    end else if (item.duty_value < {1'b0, cfg.duty_min}) begin
      duty_clamped = 8'd0;
    end else begin
      duty_clamped = item.duty_value;
    end
  end

  always_comb begin
    duty_store_next    = duty_store;
    compare_point_next = compare_point;
    tick_count_next    = tick_count;
    timer_running_next = timer_running;
    gate_level_next    = gate_level;
    case (item.mode)
      MODE_DUTY: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (int'(item.channel) == c) begin
            duty_store_next[c] = duty_clamped[6:0];
          end
        end
      end
      MODE_ZERO: begin
        tick_count_next    = 8'd0;
        timer_running_next = 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
          gate_level_next[c] = 1'b0;
          if (duty_store[c] >= cfg.duty_min) begin
            if (duty_store[c] >= PCT_FULL) begin
              compare_point_next[c] = 9'd0;
              gate_level_next[c]    = 1'b1;   // fire at the crossing itself
            end else begin
              compare_point_next[c] = {2'b00, PCT_FULL - duty_store[c]};
            end
          end else begin
            compare_point_next[c] = {1'b0, cfg.period_ticks} + OFF_MARGIN;
          end
        end
      end
      MODE_TICK: begin
        if (timer_running) begin
          tick_count_next = tick_count + 8'd1;
          for (int c = 0; c < CHANNELS; c++) begin
            if (compare_point[c] == {1'b0, tick_count_next} &&
                duty_store[c] >= cfg.duty_min) begin
              gate_level_next[c] = 1'b1;
            end
          end
          // drop both gates and stop at end of half-cycle
          if (tick_count_next >= cfg.period_ticks) begin
            gate_level_next    = '0;
            timer_running_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        duty_store[c]    <= 7'd0;
        compare_point[c] <= 9'd0;
      end
      tick_count    <= 8'd0;
      timer_running <= 1'b0;
      gate_level    <= '0;
    end else if (accept) begin
      duty_store    <= duty_store_next;
      compare_point <= compare_point_next;
      tick_count    <= tick_count_next;
      timer_running <= timer_running_next;
      gate_level    <= gate_level_next;
    end
  end

  assign gate_pad             = CHAN_PAD'(gate_level_next);
  assign result.gate_ch0      = gate_pad[0];
  assign result.gate_ch1      = gate_pad[1];
  assign result.timing_active = timer_running_next;

endmodule

`default_nettype wire

// ===== hdl/phase_angle_thyristor_firing_core.sv =====
// Result valid in the cycle after input transfer; one item per cycle while out_ready is
// high, set by the single result register (input ready while empty or being drained).
// Reset (rst, synchronous): gates low, timer stopped, duties and compare points zero,
// result register empty, registers back to duty_max 95, duty_min 5, period_ticks 100.
// Depends on patf_pkg and patf_engine.
`default_nettype none

module phase_angle_thyristor_firing_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire patf_pkg::in_t  in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output patf_pkg::out_t      out_item,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [7:0]     cfg_data
);
  import patf_pkg::*;

  cfg_t cfg;
  out_t result;
  logic accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_max     <= DUTY_MAX_RST;
      cfg.duty_min     <= DUTY_MIN_RST;
      cfg.period_ticks <= PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DUTY_MAX: cfg.duty_max     <= cfg_data[6:0];
        REG_DUTY_MIN: cfg.duty_min     <= cfg_data[6:0];
        REG_PERIOD:   cfg.period_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  patf_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  // result register: load on input transfer, clear valid on output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= result;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/patf_checker.sv =====
// Port-level checks for the firing core, attached by bind.
// Depends on patf_pkg and phase_angle_thyristor_firing_core.
`default_nettype none

module patf_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire patf_pkg::in_t  in_item,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire patf_pkg::out_t out_item
);
  import patf_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow result register");

  // a zero crossing always starts the timer
  a_zero_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.mode == MODE_ZERO |=>
      out_valid && out_item.timing_active)
    else $error("zero crossing did not start timer");

  // gates are only driven while the timer runs
  a_gates_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.timing_active |-> !out_item.gate_ch0 && !out_item.gate_ch1)
    else $error("gate high with timer stopped");

endmodule

bind phase_angle_thyristor_firing_core patf_checker u_patf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for phase_angle_thyristor_firing_core: a directed table, then
// randomized phases under sender/receiver idling, checked by predictor or typed rows.
// Depends on patf_pkg and the core RTL.
module tb;
  import patf_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int RX_HOLD     = 80;
  localparam int SETTLE      = 3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_item;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_DUTY_MAX;
  logic [7:0] cfg_data = 8'd0;

  phase_angle_thyristor_firing_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted firing state and register shadow
  cfg_t       cfg_shadow;
  logic [6:0] duty_mem [CHANNELS];
  logic [8:0] cmp_pt [CHANNELS];
  logic [7:0] tick_cnt;
  logic       timer_on;
  logic       gate_lvl [CHANNELS];

  out_t expected_levels [$];
  int   errors = 0;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   hold_requests = 0;
  int   quiet_cycles = 0;

  typedef struct {
    logic       is_reg;
    logic [1:0] sel;
    in_t        item;
    logic       typed;
    out_t       want;
  } dir_row_t;

  dir_row_t dir_tab [$];

  function automatic out_t predict_levels(in_t it);
    logic [7:0] req;
    out_t       r;
    int         c;
    req = it.duty_value;
    case (it.mode)
      MODE_DUTY: begin
        if (req > {1'b0, cfg_shadow.duty_max}) req = {1'b0, cfg_shadow.duty_max};
        else if (req < {1'b0, cfg_shadow.duty_min}) req = 8'd0;
        duty_mem[it.channel] = req[6:0];
      end
      MODE_ZERO: begin
        tick_cnt = 8'd0;
        timer_on = 1'b1;
        for (c = 0; c < CHANNELS; c++) begin
          gate_lvl[c] = 1'b0;
          if (duty_mem[c] >= cfg_shadow.duty_min) begin
            cmp_pt[c] = (duty_mem[c] >= PCT_FULL) ? 9'd0 : 9'(PCT_FULL - duty_mem[c]);
            if (cmp_pt[c] == 9'd0) gate_lvl[c] = 1'b1;
          end else begin
            // off channel: compare point the counter never reaches
            cmp_pt[c] = {1'b0, cfg_shadow.period_ticks} + OFF_MARGIN;
          end
        end
      end
      MODE_TICK: begin
        if (timer_on) begin
          tick_cnt = tick_cnt + 8'd1;
          for (c = 0; c < CHANNELS; c++) begin
            if (cmp_pt[c] == {1'b0, tick_cnt} && duty_mem[c] >= cfg_shadow.duty_min)
              gate_lvl[c] = 1'b1;
          end
          if (tick_cnt >= cfg_shadow.period_ticks) begin
            for (c = 0; c < CHANNELS; c++) gate_lvl[c] = 1'b0;
            timer_on = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.gate_ch0      = gate_lvl[0];
    r.gate_ch1      = gate_lvl[1];
    r.timing_active = timer_on;
    return r;
  endfunction

  function automatic dir_row_t item_row(logic [1:0] m, logic ch, logic [7:0] v);
    dir_row_t r;
    r.is_reg = 1'b0;
    r.sel = REG_DUTY_MAX;
    r.item.mode = m;
    r.item.channel = ch;
    r.item.duty_value = v;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic dir_row_t typed_row(logic [1:0] m, logic ch, logic [7:0] v, out_t w);
    dir_row_t r;
    r = item_row(m, ch, v);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [1:0] idx, logic [7:0] v);
    dir_row_t r;
    r = item_row(MODE_TICK, 1'b0, v);
    r.is_reg = 1'b1;
    r.sel = idx;
    return r;
  endfunction

  function automatic logic [7:0] pick_duty();
    int v;
    case ($urandom_range(5))
      0: v = $urandom_range(255);
      1: v = int'(cfg_shadow.duty_min) + int'($urandom_range(2)) - 1;
      2: v = int'(cfg_shadow.duty_max) + int'($urandom_range(2)) - 1;
      3: v = 99 + int'($urandom_range(2));
      4: v = ($urandom_range(1) == 1) ? 255 : 0;
      default: v = $urandom_range(100);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // between half cycles favor duty updates and zero crossings; while timing, ticks
  function automatic in_t pick_item();
    in_t it;
    int  roll;
    it.channel = 1'($urandom_range(1));
    it.duty_value = pick_duty();
    roll = $urandom_range(99);
    if (!timer_on) begin
      if (roll < 45) it.mode = MODE_DUTY;
      else if (roll < 82) it.mode = MODE_ZERO;
      else if (roll < 96) it.mode = MODE_TICK;
      else it.mode = MODE_UNUSED;
    end else begin
      if (roll < 86) it.mode = MODE_TICK;
      else if (roll < 93) it.mode = MODE_DUTY;
      else if (roll < 97) it.mode = MODE_ZERO;
      else it.mode = MODE_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(in_t it, logic typed, out_t want);
    out_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    pred = predict_levels(it);
    expected_levels.push_back(typed ? want : pred);
  endtask

  // hold the sender until every result has been drained
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_levels.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_DUTY_MAX: cfg_shadow.duty_max = val[6:0];
      REG_DUTY_MIN: cfg_shadow.duty_min = val[6:0];
      REG_PERIOD:   cfg_shadow.period_ticks = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic field_mismatch(string name, logic exp_v, logic act_v);
    errors++;
    $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin : rx_side
    int hold_left;
    int holds_seen;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = RX_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_out
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        errors++;
        $display("%0t: result %b transferred with nothing expected", $time, out_item);
      end else begin
        want = expected_levels.pop_front();
        if (out_item.gate_ch0 !== want.gate_ch0)
          field_mismatch("gate_ch0", want.gate_ch0, out_item.gate_ch0);
        if (out_item.gate_ch1 !== want.gate_ch1)
          field_mismatch("gate_ch1", want.gate_ch1, out_item.gate_ch1);
        if (out_item.timing_active !== want.timing_active)
          field_mismatch("timing_active", want.timing_active, out_item.timing_active);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stim
    int    ph;
    int    n;
    int    n_items;
    int    k;
    int    dmax;
    int    dmin;
    int    per;
    in_t   it;
    cfg_shadow = {DUTY_MAX_RST, DUTY_MIN_RST, PERIOD_RST};
    for (k = 0; k < CHANNELS; k++) begin
      duty_mem[k] = '0;
      cmp_pt[k]   = '0;
      gate_lvl[k] = 1'b0;
    end
    tick_cnt = '0;
    timer_on = 1'b0;

    dir_tab = '{
      typed_row(MODE_TICK,   1'b0, 8'd0,   3'b000),
      typed_row(MODE_UNUSED, 1'b1, 8'd255, 3'b000),
      typed_row(MODE_ZERO,   1'b0, 8'd0,   3'b001),
      typed_row(MODE_DUTY,   1'b0, 8'd255, 3'b001),
      typed_row(MODE_DUTY,   1'b1, 8'd4,   3'b001),
      typed_row(MODE_DUTY,   1'b1, 8'd5,   3'b001),
      reg_row(REG_PERIOD, 8'd3),
      item_row(MODE_ZERO, 1'b0, 8'd0),
      item_row(MODE_TICK, 1'b0, 8'd0),
      item_row(MODE_TICK, 1'b1, 8'd0),
      item_row(MODE_TICK, 1'b0, 8'd0),
      typed_row(MODE_TICK, 1'b0, 8'd0, 3'b000),
      reg_row(REG_DUTY_MAX, 8'd100),
      reg_row(REG_DUTY_MIN, 8'd0),
      item_row(MODE_DUTY, 1'b0, 8'd200),
      item_row(MODE_DUTY, 1'b1, 8'd0),
      item_row(MODE_ZERO, 1'b1, 8'd0),
      item_row(MODE_DUTY, 1'b0, 8'd3),
      reg_row(REG_DUTY_MIN, 8'd10),
      item_row(MODE_TICK, 1'b0, 8'd0),
      reg_row(REG_PERIOD, 8'd1),
      item_row(MODE_TICK, 1'b0, 8'd0),
      reg_row(REG_PERIOD, 8'd2),
      item_row(MODE_DUTY, 1'b0, 8'd98),
      item_row(MODE_DUTY, 1'b1, 8'd255),
      item_row(MODE_ZERO, 1'b0, 8'd0),
      item_row(MODE_TICK, 1'b0, 8'd0),
      item_row(MODE_TICK, 1'b0, 8'd0),
      reg_row(REG_DUTY_MAX, 8'd0),
      reg_row(REG_DUTY_MIN, 8'd100),
      item_row(MODE_DUTY, 1'b0, 8'd255),
      item_row(MODE_DUTY, 1'b1, 8'd50),
      item_row(MODE_ZERO, 1'b0, 8'd0),
      item_row(MODE_TICK, 1'b0, 8'd0),
      item_row(MODE_TICK, 1'b0, 8'd0)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_reg) begin
        settle();
        write_reg(dir_tab[i].sel, dir_tab[i].item.duty_value);
      end else begin
        send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (ph = 0; ph < 8; ph++) begin
      settle();
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 47; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 47; end
        default: begin tx_idle_pct = 27; rx_stall_pct <= 27; end
      endcase
      case (ph)
        0: begin dmax = 95;  dmin = 5;   per = 20;  end
        1: begin dmax = 100; dmin = 0;   per = 255; end
        2: begin dmax = 0;   dmin = 100; per = 1;   end
        7: begin
          dmax = $urandom_range(100);
          dmin = $urandom_range(100);
          per  = $urandom_range(1, 255);
        end
        default: begin
          dmax = $urandom_range(30, 100);
          dmin = $urandom_range(20);
          per  = ($urandom_range(3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 30);
        end
      endcase
      write_reg(REG_DUTY_MAX, 8'(dmax));
      write_reg(REG_DUTY_MIN, 8'(dmin));
      write_reg(REG_PERIOD, 8'(per));
      n_items = (ph == 2) ? 60 : 190;
      for (n = 0; n < n_items; n++) begin
        // stall the receiver for a long stretch while items keep coming
        if (ph == 0 && n == 40) hold_requests <= hold_requests + 1;
        if ($urandom_range(149) == 0) settle();
        it = pick_item();
        send_item(it, 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (expected_levels.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_levels.size());
    end
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/patf_pkg.sv
hdl/patf_engine.sv
hdl/phase_angle_thyristor_firing_core.sv
hdl/patf_checker.sv
bench/tb.sv
